// ----- rtl/hpt_pkg.sv -----
// Shared types, constants and the sRGB threshold table of the tone mapper.
`default_nettype none

package hpt_pkg;

   localparam int CHAN_COUNT  = 3;
   localparam int IN_W        = 20;
   localparam int KNEE_W      = 13;
   localparam int SCALE_W     = 16;
   localparam int BYTE_W      = 8;
   localparam int SRGB_LEVELS = 255;
   localparam int THRESH_W    = 33;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
   localparam int BIG_W       = 384;

   localparam logic [THRESH_W-1:0] Y_ONE = {1'b1, {(THRESH_W - 1){1'b0}}};

   // Register byte offsets
   localparam logic [2:0] REG_KNEE  = 3'd0;
   localparam logic [2:0] REG_SCALE = 3'd4;

   typedef enum logic [1:0] {
      CH_ZERO,
      CH_PASS,
      CH_ROLL
   } chan_code_type;

   typedef struct packed {
      chan_code_type     code;
      logic [IN_W-1:0]   mag;
   } chan_item_type;

   typedef struct packed {
      chan_item_type [CHAN_COUNT-1:0] ch;
      logic [BYTE_W-1:0]              alpha;
   } front_item_type;

   typedef logic [THRESH_W-1:0] thresh_rom_type [SRGB_LEVELS];

   // Exact sRGB decision thresholds in Q.32, worked out at elaboration.
   function automatic thresh_rom_type build_thresholds();
      thresh_rom_type rom;
      logic [BIG_W-1:0] base;
      logic [BIG_W-1:0] numpow;
      logic [BIG_W-1:0] lhs;
      logic [BIG_W-1:0] rhs;
      logic [THRESH_W-1:0] lo;
      logic [THRESH_W-1:0] hi;
      logic [THRESH_W-1:0] mid;
      logic [63:0] lin;
      int k;
      int i;
      base = BIG_W'(1);
      for (i = 0; i < 12; i++) begin
         base = base * BIG_W'(53805);
      end
      for (k = 0; k < SRGB_LEVELS; k++) begin
         if (k <= 9) begin
            lin = (64'(2 * k + 1) * 64'd5 * 64'h1_0000_0000 + 64'd32945) / 64'd32946;
            rom[k] = lin[THRESH_W-1:0];
         end else begin
            numpow = BIG_W'(1);
            for (i = 0; i < 12; i++) begin
               numpow = numpow * BIG_W'(200 * k + 2905);
            end
            rhs = numpow << 160;
            lo = '0;
            hi = Y_ONE;
            while (lo < hi) begin
               mid = lo + ((hi - lo) >> 1);
               lhs = base;
               for (i = 0; i < 5; i++) begin
                  lhs = lhs * BIG_W'(mid);
               end
               if (lhs >= rhs) begin
                  hi = mid;
               end else begin
                  lo = mid + THRESH_W'(1);
               end
            end
            rom[k] = lo;
         end
      end
      return rom;
   endfunction

   localparam thresh_rom_type SRGB_THRESH = build_thresholds();

endpackage

`default_nettype wire

// ----- rtl/hpt_pixel_if.sv -----
// Channel interfaces for the HDR input pixel and the 8-bit result pixel.
`default_nettype none

interface hpt_pixel_req_if;
   logic               valid;
   logic               ready;
   logic signed [19:0] red_in;
   logic signed [19:0] green_in;
   logic signed [19:0] blue_in;
   logic signed [19:0] alpha_in;

   modport source (output valid, red_in, green_in, blue_in, alpha_in, input ready);
   modport sink   (input valid, red_in, green_in, blue_in, alpha_in, output ready);
endinterface

interface hpt_pixel_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] red_out;
   logic [7:0] green_out;
   logic [7:0] blue_out;
   logic [7:0] alpha_out;

   modport source (output valid, red_out, green_out, blue_out, alpha_out, input ready);
   modport sink   (input valid, red_out, green_out, blue_out, alpha_out, output ready);
endinterface

`default_nettype wire

// ----- rtl/hdr_pixel_tone_mapper.sv -----
// Top level of the HDR pixel tone mapper: register file, front, queue, back.
`default_nettype none

// Usage
//   req_port carries one linear RGBA pixel per transaction, each component
//   signed fixed point with FRAC_BITS fraction bits. rsp_port returns one
//   8-bit RGBA pixel per transaction, in order: sRGB-encoded colour after the
//   highlight rolloff, alpha clamped and scaled to a byte.
//   The APB-style port holds knee_point at 0x0 and rolloff_scale at 0x4;
//   write them only while no pixel is in flight.
// Throughput: one pixel per clock, sustained while rsp_port is ready.
// Path: a pixel passes from acceptance to the result being offered through the
//   front register, the queue, the division pipeline that retires one quotient
//   bit per stage, the saturation stage, then the eight-stage search of the
//   sRGB threshold table.
// Reset: synchronous; empties the front register, the queue and every
//   pipeline stage, and loads knee 0.5 and scale 2137.
// Stall: when rsp_port is not ready the back pipeline holds; the front keeps
//   accepting until its register and the four-entry queue are full, then
//   drops ready.
module hdr_pixel_tone_mapper
   import hpt_pkg::*;
#(
   parameter int FRAC_BITS = 12
) (
   input  wire logic        clock,
   input  wire logic        reset,
   hpt_pixel_req_if.sink    req_port,
   hpt_pixel_rsp_if.source  rsp_port,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [2:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);

   logic [KNEE_W-1:0]  knee_ff;
   logic [SCALE_W-1:0] scale_ff;
   logic               wr_en;
   front_item_type     push_item;
   front_item_type     head_item;
   logic               push;
   logic               q_full;
   logic               q_not_empty;
   logic               pop;

   // Registers are decoded on address bit 2 alone
   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;

   always_comb begin
      if ((paddr & REG_SCALE) == REG_SCALE) begin
         prdata = 32'(scale_ff);
      end else begin
         prdata = 32'(knee_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         knee_ff  <= KNEE_W'(2048);
         scale_ff <= SCALE_W'(2137);
      end else if (wr_en) begin
         if ((paddr & REG_SCALE) == REG_KNEE) begin
            knee_ff <= pwdata[KNEE_W-1:0];
         end else begin
            scale_ff <= pwdata[SCALE_W-1:0];
         end
      end
   end

   // Classify pixels as they arrive
   hpt_front #(
      .FRAC_BITS (FRAC_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_port  (req_port),
      .knee      (knee_ff),
      .q_full    (q_full),
      .push_item (push_item),
      .push      (push)
   );

   // Decouple the two halves so either may stall alone
   hpt_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (q_full),
      .pop       (pop),
      .not_empty (q_not_empty),
      .head_item (head_item)
   );

   // Carry out the rolloff, division and encoding
   hpt_back #(
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .knee        (knee_ff),
      .scale       (scale_ff),
      .q_not_empty (q_not_empty),
      .head_item   (head_item),
      .pop         (pop),
      .rsp_port    (rsp_port)
   );

endmodule

`default_nettype wire

// ----- rtl/hpt_front.sv -----
// Front end: accept pixels, classify each colour channel, encode alpha.
`default_nettype none

module hpt_front
   import hpt_pkg::*;
#(
   parameter int FRAC_BITS = 12
) (
   input  wire logic              clock,
   input  wire logic              reset,
   hpt_pixel_req_if.sink          req_port,
   input  wire logic [KNEE_W-1:0] knee,
   input  wire logic              q_full,
   output front_item_type         push_item,
   output logic                   push
);

   localparam int AW = FRAC_BITS + 9;

   logic           vld_ff;
   logic           vld_in;
   front_item_type item_ff;
   front_item_type item_in;
   logic           take;

   function automatic chan_item_type classify(logic signed [IN_W-1:0] v,
                                              logic [KNEE_W-1:0] k);
      chan_item_type c;
      c.mag  = '0;
      c.code = CH_ZERO;
      if (v[IN_W-1] || (v == '0)) begin
         c.code = CH_ZERO;
      end else if (IN_W'(v) <= IN_W'(k)) begin
         c.code = CH_PASS;
         c.mag  = IN_W'(v);
      end else begin
         c.code = CH_ROLL;
         c.mag  = IN_W'(v) - IN_W'(k);
      end
      return c;
   endfunction

   function automatic logic [BYTE_W-1:0] encode_alpha(logic signed [IN_W-1:0] v);
      logic [AW-1:0]     p;
      logic [BYTE_W-1:0] b;
      p = AW'(v[FRAC_BITS-1:0]) * AW'(255) + (AW'(1) << (FRAC_BITS - 1));
      if (v[IN_W-1] || (v == '0)) begin
         b = '0;
      end else if (v[IN_W-2:0] >= ((IN_W - 1)'(1) << FRAC_BITS)) begin
         b = 8'hFF;
      end else begin
         b = p[FRAC_BITS+BYTE_W-1:FRAC_BITS];
      end
      return b;
   endfunction

   // Advance the front register whenever it is empty or its item moves on
   assign push           = vld_ff && !q_full;
   assign take           = !vld_ff || !q_full;
   assign req_port.ready = take;
   assign push_item      = item_ff;

   always_comb begin
      vld_in        = vld_ff;
      item_in       = item_ff;
      if (take) begin
         vld_in        = req_port.valid;
         item_in.ch[0] = classify(req_port.red_in, knee);
         item_in.ch[1] = classify(req_port.green_in, knee);
         item_in.ch[2] = classify(req_port.blue_in, knee);
         item_in.alpha = encode_alpha(req_port.alpha_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
      item_ff <= item_in;
   end

endmodule

`default_nettype wire

// ----- rtl/hpt_queue.sv -----
// Short queue between the classifying front end and the arithmetic back end.
`default_nettype none

module hpt_queue
   import hpt_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     push,
   input  wire front_item_type push_item,
   output logic          full,
   input  wire logic     pop,
   output logic          not_empty,
   output front_item_type head_item
);

   front_item_type    mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff;
   logic [QPTR_W-1:0] rd_ptr_ff;
   logic [QCNT_W-1:0] count_ff;
   logic [QCNT_W-1:0] count_in;

   assign full      = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head_item = mem_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         end
         count_ff <= count_in;
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("queue count beyond depth");

   a_no_pop_empty : assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty)
      else $error("pop from empty queue");

   a_no_push_full : assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("push into full queue");

endmodule

`default_nettype wire

// ----- rtl/hpt_back.sv -----
// Back end: rolloff multiply, pipelined division, saturation and sRGB search.
`default_nettype none

module hpt_back
   import hpt_pkg::*;
#(
   parameter int FRAC_BITS = 12
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic [KNEE_W-1:0]  knee,
   input  wire logic [SCALE_W-1:0] scale,
   input  wire logic               q_not_empty,
   input  wire front_item_type     head_item,
   output logic                    pop,
   hpt_pixel_rsp_if.source         rsp_port
);

   localparam int Y_SHIFT = 32 - FRAC_BITS;
   localparam int QW      = SCALE_W + Y_SHIFT;
   localparam int PW      = SCALE_W + IN_W;
   localparam int SW      = SCALE_W + Y_SHIFT + 2;
   localparam int SRCH    = 8;
   localparam int NST     = QW + SRCH + 2;

   logic              vld_ff   [NST];
   logic [BYTE_W-1:0] alpha_ff [NST];
   logic              adv;
   logic [BYTE_W-1:0] lane_byte [CHAN_COUNT];

   // Whole pipeline moves when the output register is free or being taken
   assign adv            = !vld_ff[NST-1] || rsp_port.ready;
   assign pop            = adv && q_not_empty;
   assign rsp_port.valid = vld_ff[NST-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < NST; s++) begin
            vld_ff[s] <= 1'b0;
         end
      end else if (adv) begin
         vld_ff[0] <= q_not_empty;
         for (int s = 1; s < NST; s++) begin
            vld_ff[s] <= vld_ff[s-1];
         end
      end
      if (adv) begin
         alpha_ff[0] <= head_item.alpha;
         for (int s = 1; s < NST; s++) begin
            alpha_ff[s] <= alpha_ff[s-1];
         end
      end
   end

   for (genvar l = 0; l < CHAN_COUNT; l++) begin : g_lane
      chan_code_type     code_ff [QW+1];
      logic [IN_W-1:0]   mag_ff  [QW+1];
      logic [PW-1:0]     prod_ff;
      logic [IN_W-1:0]   den_ff  [QW];
      logic [IN_W-1:0]   rem_ff  [1:QW];
      logic [QW-1:0]     sh_ff   [1:QW];
      logic [IN_W-1:0]   rem_in  [1:QW];
      logic [QW-1:0]     sh_in   [1:QW];
      logic [THRESH_W-1:0] y_ff  [SRCH];
      logic [THRESH_W-1:0] y_in;
      logic [BYTE_W-1:0] res_ff  [1:SRCH];
      logic [BYTE_W-1:0] res_in  [1:SRCH];
      logic [SW-1:0]     ysum;

      // One quotient bit per stage, restoring
      always_comb begin
         logic [IN_W-1:0] pr;
         logic [QW-1:0]   ps;
         logic [IN_W:0]   trial;
         for (int j = 1; j <= QW; j++) begin
            if (j == 1) begin
               pr = prod_ff[PW-1:SCALE_W];
               ps = {prod_ff[SCALE_W-1:0], {Y_SHIFT{1'b0}}};
            end else begin
               pr = rem_ff[j-1];
               ps = sh_ff[j-1];
            end
            trial = {pr, ps[QW-1]};
            if (trial >= {1'b0, den_ff[j-1]}) begin
               rem_in[j] = IN_W'(trial - {1'b0, den_ff[j-1]});
               sh_in[j]  = {ps[QW-2:0], 1'b1};
            end else begin
               rem_in[j] = trial[IN_W-1:0];
               sh_in[j]  = {ps[QW-2:0], 1'b0};
            end
         end
      end

      // Assemble the tone-mapped value in Q.32 and saturate at one
      always_comb begin
         ysum = '0;
         case (code_ff[QW])
            CH_PASS: ysum = SW'(mag_ff[QW]) << Y_SHIFT;
            CH_ROLL: ysum = (SW'(knee) << Y_SHIFT) + SW'(sh_ff[QW]);
            default: ysum = '0;
         endcase
         if (ysum > SW'(Y_ONE)) begin
            y_in = Y_ONE;
         end else begin
            y_in = ysum[THRESH_W-1:0];
         end
      end

      // Binary search over the threshold table, one bit of the byte a stage
      always_comb begin
         logic [BYTE_W-1:0] pres;
         logic [BYTE_W-1:0] cand;
         for (int k = 1; k <= SRCH; k++) begin
            pres = (k == 1) ? '0 : res_ff[k-1];
            cand = pres | (BYTE_W'(1) << (SRCH - k));
            if (y_ff[k-1] >= SRGB_THRESH[cand - BYTE_W'(1)]) begin
               res_in[k] = cand;
            end else begin
               res_in[k] = pres;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            code_ff[0] <= head_item.ch[l].code;
            mag_ff[0]  <= head_item.ch[l].mag;
            den_ff[0]  <= head_item.ch[l].mag + IN_W'(scale);
            prod_ff    <= PW'(scale) * PW'(head_item.ch[l].mag);
            for (int j = 1; j <= QW; j++) begin
               code_ff[j] <= code_ff[j-1];
               mag_ff[j]  <= mag_ff[j-1];
               if (j < QW) begin
                  den_ff[j] <= den_ff[j-1];
               end
               rem_ff[j]  <= rem_in[j];
               sh_ff[j]   <= sh_in[j];
            end
            y_ff[0] <= y_in;
            for (int k = 1; k < SRCH; k++) begin
               y_ff[k] <= y_ff[k-1];
            end
            for (int k = 1; k <= SRCH; k++) begin
               res_ff[k] <= res_in[k];
            end
         end
      end

      assign lane_byte[l] = res_ff[SRCH];
   end

   assign rsp_port.red_out   = lane_byte[0];
   assign rsp_port.green_out = lane_byte[1];
   assign rsp_port.blue_out  = lane_byte[2];
   assign rsp_port.alpha_out = alpha_ff[NST-1];

endmodule

`default_nettype wire
